>>> sv/tvc_pkg.sv
// Shared types, widths and codes for the tile viewport clip block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tvc_pkg;

   // field and register widths
   localparam int POS_W      = 21;
   localparam int TILE_IDX_W = 12;
   localparam int TSZ_W      = 9;
   localparam int WT_W       = 13;
   localparam int WIN_W      = 13;
   localparam int PIX_W      = 21;
   localparam int RECT_W     = 20;
   localparam int SKIP_W     = 8;
   localparam int USED_W     = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int MAX_TILE_SIZE   = 256;
   localparam int MAX_WORLD_TILES = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_HEIGHT   = 3'd5;

   // item kinds
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [POS_W-1:0]      pos_x;
      logic [POS_W-1:0]      pos_y;
      logic [TILE_IDX_W-1:0] tile_col;
      logic [TILE_IDX_W-1:0] tile_row;
   } req_word_type;

   typedef struct packed {
      logic [TILE_IDX_W-1:0] first_col;
      logic [TILE_IDX_W-1:0] first_row;
      logic [TILE_IDX_W-1:0] last_col;
      logic [TILE_IDX_W-1:0] last_row;
      logic [SKIP_W-1:0]     left_skip;
      logic [SKIP_W-1:0]     top_skip;
      logic [USED_W-1:0]     right_used;
      logic [USED_W-1:0]     bottom_used;
      logic [RECT_W-1:0]     rect_x;
      logic [RECT_W-1:0]     rect_y;
      logic [USED_W-1:0]     rect_w;
      logic [USED_W-1:0]     rect_h;
   } rsp_word_type;

   typedef struct packed {
      logic load_req;
      logic world_mul;
      logic lim_calc;
      logic clamp_calc;
      logic div_start;
      logic upd_write;
      logic query_mul;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UMUL,
      ST_ULIM,
      ST_UCLAMP,
      ST_UDIVGO,
      ST_UDIV,
      ST_UWRITE,
      ST_QMUL,
      ST_DONE
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> sv/tvc_req_if.sv
// Request channel of the tile viewport clip block: valid/ready plus one input word.
// Depends on tvc_pkg for field widths.
`default_nettype none

interface tvc_req_if import tvc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [POS_W-1:0]      pos_x;
   logic signed [POS_W-1:0]      pos_y;
   logic        [TILE_IDX_W-1:0] tile_col;
   logic        [TILE_IDX_W-1:0] tile_row;

   modport source (output valid, kind, pos_x, pos_y, tile_col, tile_row, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, tile_col, tile_row, output ready);
endinterface

`default_nettype wire

>>> sv/tvc_rsp_if.sv
// Response channel of the tile viewport clip block: valid/ready plus one result word.
// Depends on tvc_pkg for field widths.
`default_nettype none

interface tvc_rsp_if import tvc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TILE_IDX_W-1:0] first_col;
   logic [TILE_IDX_W-1:0] first_row;
   logic [TILE_IDX_W-1:0] last_col;
   logic [TILE_IDX_W-1:0] last_row;
   logic [SKIP_W-1:0]     left_skip;
   logic [SKIP_W-1:0]     top_skip;
   logic [USED_W-1:0]     right_used;
   logic [USED_W-1:0]     bottom_used;
   logic [RECT_W-1:0]     rect_x;
   logic [RECT_W-1:0]     rect_y;
   logic [USED_W-1:0]     rect_w;
   logic [USED_W-1:0]     rect_h;

   modport source (output valid, first_col, first_row, last_col, last_row, left_skip,
                   top_skip, right_used, bottom_used, rect_x, rect_y, rect_w, rect_h,
                   input ready);
   modport sink   (input valid, first_col, first_row, last_col, last_row, left_skip,
                   top_skip, right_used, bottom_used, rect_x, rect_y, rect_w, rect_h,
                   output ready);
endinterface

`default_nettype wire

>>> sv/tile_viewport_clip_core.sv
// Tile viewport clip unit. A viewport update word clamps the window into the world and
// records the visible tile range; it passes the multiply, limit and clamp stages and the
// 21-step restoring dividers (one quotient bit per cycle, both axes and both window edges
// in parallel) before the next word can be accepted. A tile query word reads the stored
// range. One word is in flight at a time; a finished result sits in the output register
// while the next word is accepted.
// Depends on tvc_pkg, tvc_req_if, tvc_rsp_if, tvc_div, tvc_dp and tvc_ctrl.
`default_nettype none

module tile_viewport_clip_core import tvc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   tvc_req_if.sink                    req_chan,
   tvc_rsp_if.source                  rsp_chan
);

   req_word_type  req_word;
   rsp_word_type  rsp_word;
   dp_cmd_type    cmd;
   dp_status_type sts;
   logic          req_ready;
   logic          rsp_valid;

   assign req_word.kind     = req_chan.kind;
   assign req_word.pos_x    = req_chan.pos_x;
   assign req_word.pos_y    = req_chan.pos_y;
   assign req_word.tile_col = req_chan.tile_col;
   assign req_word.tile_row = req_chan.tile_row;
   assign req_chan.ready    = req_ready;

   tvc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_kind (req_chan.kind),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   tvc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.first_col   = rsp_word.first_col;
   assign rsp_chan.first_row   = rsp_word.first_row;
   assign rsp_chan.last_col    = rsp_word.last_col;
   assign rsp_chan.last_row    = rsp_word.last_row;
   assign rsp_chan.left_skip   = rsp_word.left_skip;
   assign rsp_chan.top_skip    = rsp_word.top_skip;
   assign rsp_chan.right_used  = rsp_word.right_used;
   assign rsp_chan.bottom_used = rsp_word.bottom_used;
   assign rsp_chan.rect_x      = rsp_word.rect_x;
   assign rsp_chan.rect_y      = rsp_word.rect_y;
   assign rsp_chan.rect_w      = rsp_word.rect_w;
   assign rsp_chan.rect_h      = rsp_word.rect_h;

endmodule

`default_nettype wire

>>> sv/tvc_div.sv
// Restoring unsigned divider, one quotient bit per cycle, registered results.
// Depends on tvc_pkg for default widths.
`default_nettype none

module tvc_div import tvc_pkg::*; #(
   parameter int DIVIDEND_W = PIX_W,
   parameter int DIVISOR_W  = TSZ_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic      [DIVIDEND_W-1:0] quotient,
   output logic      [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits     = rem_sh >= {1'b0, divisor_ff};
      rem_diff = rem_sh - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         if (count_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
         end else begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && count_ff == LAST_STEP) |=> (rem_ff < divisor_ff))
      else $error("final remainder not below divisor");

endmodule

`default_nettype wire

>>> sv/tvc_dp.sv
// Datapath of the tile viewport clip block: config registers, viewport state,
// clamp and multiply stages, four tvc_div dividers and the result register.
// Depends on tvc_pkg and tvc_div.
`default_nettype none

module tvc_dp import tvc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire req_word_type          req_word,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              sts,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output rsp_word_type               rsp_word
);

   // axis 0 is horizontal, axis 1 vertical
   logic [TSZ_W-1:0]      tile_size_ff   [2];
   logic [WT_W-1:0]       world_tiles_ff [2];
   logic [WIN_W-1:0]      win_size_ff    [2];

   logic [TSZ_W-1:0]      tsz  [2];
   logic [WT_W-1:0]       wt   [2];
   logic [WIN_W-1:0]      win  [2];

   logic                  kind_ff;
   logic [POS_W-1:0]      pos_ff   [2];
   logic [TILE_IDX_W-1:0] tile_ff  [2];
   logic [PIX_W-1:0]      world_ff [2];
   logic [PIX_W-1:0]      lim_ff   [2];
   logic [PIX_W-1:0]      start_ff [2];
   logic [PIX_W-1:0]      qprod_ff [2];

   logic [TILE_IDX_W-1:0] first_ff [2];
   logic [TILE_IDX_W-1:0] last_ff  [2];
   logic [SKIP_W-1:0]     skip_ff  [2];
   logic [USED_W-1:0]     used_ff  [2];

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic [WT_W+TSZ_W-1:0] world_prod [2];
   logic [PIX_W:0]        lim_diff   [2];
   logic [PIX_W-1:0]      clamp_pos  [2];
   logic [PIX_W-1:0]      end_pix    [2];
   logic [PIX_W-1:0]      qmul       [2];
   logic [PIX_W-1:0]      div_s_q    [2];
   logic [PIX_W-1:0]      div_e_q    [2];
   logic [TSZ_W-1:0]      div_s_r    [2];
   logic [TSZ_W-1:0]      div_e_r    [2];
   logic [1:0]            div_s_busy;
   logic [1:0]            div_e_busy;
   logic [PIX_W-1:0]      clip_pos   [2];
   logic [USED_W-1:0]     clip_len   [2];
   logic [PIX_W-1:0]      skip_pos   [2];

   function automatic logic [TSZ_W-1:0] fix_tile(input logic [TSZ_W-1:0] v);
      logic [TSZ_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = TSZ_W'(1);
      end else if (v > TSZ_W'(MAX_TILE_SIZE)) begin
         r = TSZ_W'(MAX_TILE_SIZE);
      end
      return r;
   endfunction

   function automatic logic [WT_W-1:0] fix_world(input logic [WT_W-1:0] v);
      logic [WT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = WT_W'(1);
      end else if (v > WT_W'(MAX_WORLD_TILES)) begin
         r = WT_W'(MAX_WORLD_TILES);
      end
      return r;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff[0]   <= TSZ_W'(16);
         tile_size_ff[1]   <= TSZ_W'(16);
         world_tiles_ff[0] <= WT_W'(64);
         world_tiles_ff[1] <= WT_W'(64);
         win_size_ff[0]    <= WIN_W'(320);
         win_size_ff[1]    <= WIN_W'(240);
      end else if (csr_we) begin
         case (csr_index)
            CSR_TILE_WIDTH:   tile_size_ff[0]   <= csr_wdata[TSZ_W-1:0];
            CSR_TILE_HEIGHT:  tile_size_ff[1]   <= csr_wdata[TSZ_W-1:0];
            CSR_WORLD_WIDTH:  world_tiles_ff[0] <= csr_wdata[WT_W-1:0];
            CSR_WORLD_HEIGHT: world_tiles_ff[1] <= csr_wdata[WT_W-1:0];
            CSR_WIN_WIDTH:    win_size_ff[0]    <= csr_wdata[WIN_W-1:0];
            CSR_WIN_HEIGHT:   win_size_ff[1]    <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         tsz[a] = fix_tile(tile_size_ff[a]);
         wt[a]  = fix_world(world_tiles_ff[a]);
         win[a] = (win_size_ff[a] == '0) ? WIN_W'(1) : win_size_ff[a];

         world_prod[a] = wt[a] * tsz[a];
         // floor the clamp limit at zero
         lim_diff[a]   = {1'b0, world_ff[a]} - (PIX_W + 1)'(win[a]);

         if (pos_ff[a][POS_W-1]) begin
            clamp_pos[a] = '0;
         end else if (pos_ff[a] > lim_ff[a]) begin
            clamp_pos[a] = lim_ff[a];
         end else begin
            clamp_pos[a] = pos_ff[a];
         end

         end_pix[a] = start_ff[a] + PIX_W'(win[a]);
         qmul[a]    = PIX_W'(tile_ff[a]) * PIX_W'(tsz[a]);

         // trim the first tile, else the last; a tile that is both is trimmed as first
         skip_pos[a] = qprod_ff[a] + PIX_W'(skip_ff[a]);
         if (tile_ff[a] == first_ff[a]) begin
            clip_pos[a] = skip_pos[a];
            clip_len[a] = (USED_W'(skip_ff[a]) > tsz[a]) ? '0
                                                         : tsz[a] - USED_W'(skip_ff[a]);
         end else if (tile_ff[a] == last_ff[a]) begin
            clip_pos[a] = qprod_ff[a];
            clip_len[a] = used_ff[a];
         end else begin
            clip_pos[a] = qprod_ff[a];
            clip_len[a] = tsz[a];
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_axis
      tvc_div #(
         .DIVIDEND_W(PIX_W),
         .DIVISOR_W (TSZ_W)
      ) u_div_start (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (start_ff[g]),
         .divisor  (tsz[g]),
         .busy     (div_s_busy[g]),
         .quotient (div_s_q[g]),
         .remainder(div_s_r[g])
      );

      tvc_div #(
         .DIVIDEND_W(PIX_W),
         .DIVISOR_W (TSZ_W)
      ) u_div_end (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (end_pix[g]),
         .divisor  (tsz[g]),
         .busy     (div_e_busy[g]),
         .quotient (div_e_q[g]),
         .remainder(div_e_r[g])
      );
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff    <= req_word.kind;
         pos_ff[0]  <= req_word.pos_x;
         pos_ff[1]  <= req_word.pos_y;
         tile_ff[0] <= req_word.tile_col;
         tile_ff[1] <= req_word.tile_row;
      end
      for (int a = 0; a < 2; a++) begin
         if (cmd.world_mul) begin
            world_ff[a] <= world_prod[a][PIX_W-1:0];
         end
         if (cmd.lim_calc) begin
            lim_ff[a] <= lim_diff[a][PIX_W] ? '0 : lim_diff[a][PIX_W-1:0];
         end
         if (cmd.clamp_calc) begin
            start_ff[a] <= clamp_pos[a];
         end
         if (cmd.query_mul) begin
            qprod_ff[a] <= qmul[a];
         end
      end
   end

   // viewport state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            first_ff[a] <= '0;
            last_ff[a]  <= '0;
            skip_ff[a]  <= '0;
            used_ff[a]  <= '0;
         end
      end else if (cmd.upd_write) begin
         for (int a = 0; a < 2; a++) begin
            first_ff[a] <= div_s_q[a][TILE_IDX_W-1:0];
            skip_ff[a]  <= div_s_r[a][SKIP_W-1:0];
            // an exact end falls on the previous tile, used in full
            if (div_e_r[a] == '0) begin
               last_ff[a] <= div_e_q[a][TILE_IDX_W-1:0] - 1'b1;
               used_ff[a] <= USED_W'(tsz[a]);
            end else begin
               last_ff[a] <= div_e_q[a][TILE_IDX_W-1:0];
               used_ff[a] <= USED_W'(div_e_r[a]);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_word_ff.first_col   <= first_ff[0];
         rsp_word_ff.first_row   <= first_ff[1];
         rsp_word_ff.last_col    <= last_ff[0];
         rsp_word_ff.last_row    <= last_ff[1];
         rsp_word_ff.left_skip   <= skip_ff[0];
         rsp_word_ff.top_skip    <= skip_ff[1];
         rsp_word_ff.right_used  <= used_ff[0];
         rsp_word_ff.bottom_used <= used_ff[1];
         if (kind_ff == KIND_QUERY) begin
            rsp_word_ff.rect_x <= clip_pos[0][RECT_W-1:0];
            rsp_word_ff.rect_y <= clip_pos[1][RECT_W-1:0];
            rsp_word_ff.rect_w <= clip_len[0];
            rsp_word_ff.rect_h <= clip_len[1];
         end else begin
            rsp_word_ff.rect_x <= '0;
            rsp_word_ff.rect_y <= '0;
            rsp_word_ff.rect_w <= '0;
            rsp_word_ff.rect_h <= '0;
         end
      end
   end

   assign sts.div_busy = (|div_s_busy) | (|div_e_busy);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_write |=> (used_ff[0] != '0) && (used_ff[1] != '0))
      else $error("last tile used width is zero after update");

endmodule

`default_nettype wire

>>> sv/tvc_ctrl.sv
// Controller of the tile viewport clip block: sequences one word through
// the datapath stages. Depends on tvc_pkg.
`default_nettype none

module tvc_ctrl import tvc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   output logic               req_ready,
   input  wire dp_status_type sts,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_kind == KIND_QUERY) ? ST_QMUL : ST_UMUL;
            end
         end
         ST_UMUL: begin
            cmd.world_mul = 1'b1;
            state_in      = ST_ULIM;
         end
         ST_ULIM: begin
            cmd.lim_calc = 1'b1;
            state_in     = ST_UCLAMP;
         end
         ST_UCLAMP: begin
            cmd.clamp_calc = 1'b1;
            state_in       = ST_UDIVGO;
         end
         ST_UDIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_UDIV;
         end
         ST_UDIV: begin
            if (!sts.div_busy) begin
               state_in = ST_UWRITE;
            end
         end
         ST_UWRITE: begin
            cmd.upd_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_QMUL: begin
            cmd.query_mul = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register can take the word
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten while occupied");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for tile_viewport_clip_core: directed and random viewport
// updates and tile queries, each checked against an in-bench viewport predictor.
// Depends on tvc_pkg, tvc_req_if, tvc_rsp_if and the block itself.

module testbench;
   import tvc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 150;
   localparam int WIN_MAX     = 8191;

   // Viewport predictor and store of expected result words.
   class viewport_board;
      bit [TSZ_W-1:0]      tile_w = 16, tile_h = 16;
      bit [WT_W-1:0]       world_w = 64, world_h = 64;
      bit [WIN_W-1:0]      win_w = 320, win_h = 240;
      bit [TILE_IDX_W-1:0] first_col, first_row, last_col, last_row;
      bit [SKIP_W-1:0]     left_skip, top_skip;
      bit [USED_W-1:0]     right_used, bottom_used;
      rsp_word_type        expected_q[$];
      int                  errors;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TILE_WIDTH:   tile_w  = data[TSZ_W-1:0];
            CSR_TILE_HEIGHT:  tile_h  = data[TSZ_W-1:0];
            CSR_WORLD_WIDTH:  world_w = data[WT_W-1:0];
            CSR_WORLD_HEIGHT: world_h = data[WT_W-1:0];
            CSR_WIN_WIDTH:    win_w   = data[WIN_W-1:0];
            CSR_WIN_HEIGHT:   win_h   = data[WIN_W-1:0];
            default: ;
         endcase
      endfunction

      function longint bounded(longint v, longint hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void split_axis(longint pos, longint tsz, longint tiles, longint win,
                               output bit [TILE_IDX_W-1:0] first,
                               output bit [SKIP_W-1:0] skip,
                               output bit [TILE_IDX_W-1:0] last,
                               output bit [USED_W-1:0] used);
         longint lim, start, stop, lt, rem;
         lim = tiles * tsz - win;
         if (lim < 0) lim = 0;
         start = pos < 0 ? 0 : (pos > lim ? lim : pos);
         stop  = start + win;
         first = TILE_IDX_W'(start / tsz);
         skip  = SKIP_W'(start % tsz);
         lt    = stop / tsz;
         rem   = stop % tsz;
         // window ending on a tile edge: last tile is the previous one, fully used
         if (rem == 0) begin
            lt  = lt - 1;
            rem = tsz;
         end
         last = TILE_IDX_W'(lt);
         used = USED_W'(rem);
      endfunction

      function void clip_axis(longint t, longint tsz, longint first, longint skip,
                              longint last, longint used,
                              output bit [RECT_W-1:0] pos, output bit [USED_W-1:0] len);
         longint p, l;
         p = t * tsz;
         l = tsz;
         if (t == first) begin
            p = p + skip;
            l = skip > tsz ? 0 : tsz - skip;
         end else if (t == last) begin
            l = used;
         end
         pos = RECT_W'(p);
         len = USED_W'(l);
      endfunction

      function void note_word(req_word_type w);
         longint              tw, th, px, py;
         bit [RECT_W-1:0]     rx, ry;
         bit [USED_W-1:0]     rw, rh;
         rsp_word_type        r;
         tw = bounded(tile_w, MAX_TILE_SIZE);
         th = bounded(tile_h, MAX_TILE_SIZE);
         r  = '0;
         if (w.kind == KIND_UPDATE) begin
            px = $signed(w.pos_x);
            py = $signed(w.pos_y);
            split_axis(px, tw, bounded(world_w, MAX_WORLD_TILES), bounded(win_w, WIN_MAX),
                       first_col, left_skip, last_col, right_used);
            split_axis(py, th, bounded(world_h, MAX_WORLD_TILES), bounded(win_h, WIN_MAX),
                       first_row, top_skip, last_row, bottom_used);
         end else begin
            clip_axis(w.tile_col, tw, first_col, left_skip, last_col, right_used, rx, rw);
            clip_axis(w.tile_row, th, first_row, top_skip, last_row, bottom_used, ry, rh);
            r.rect_x = rx;
            r.rect_y = ry;
            r.rect_w = rw;
            r.rect_h = rh;
         end
         r.first_col   = first_col;
         r.first_row   = first_row;
         r.last_col    = last_col;
         r.last_row    = last_row;
         r.left_skip   = left_skip;
         r.top_skip    = top_skip;
         r.right_used  = right_used;
         r.bottom_used = bottom_used;
         expected_q.push_back(r);
      endfunction

      function string show(rsp_word_type r);
         return $sformatf({"fc=%0d fr=%0d lc=%0d lr=%0d ls=%0d ts=%0d ru=%0d bu=%0d",
                           " rx=%0d ry=%0d rw=%0d rh=%0d"},
                          r.first_col, r.first_row, r.last_col, r.last_row, r.left_skip,
                          r.top_skip, r.right_used, r.bottom_used, r.rect_x, r.rect_y,
                          r.rect_w, r.rect_h);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         string        wrong;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word: %s", show(got));
            return;
         end
         want  = expected_q.pop_front();
         wrong = "";
         if (got.first_col   !== want.first_col)   wrong = {wrong, " first_col"};
         if (got.first_row   !== want.first_row)   wrong = {wrong, " first_row"};
         if (got.last_col    !== want.last_col)    wrong = {wrong, " last_col"};
         if (got.last_row    !== want.last_row)    wrong = {wrong, " last_row"};
         if (got.left_skip   !== want.left_skip)   wrong = {wrong, " left_skip"};
         if (got.top_skip    !== want.top_skip)    wrong = {wrong, " top_skip"};
         if (got.right_used  !== want.right_used)  wrong = {wrong, " right_used"};
         if (got.bottom_used !== want.bottom_used) wrong = {wrong, " bottom_used"};
         if (got.rect_x      !== want.rect_x)      wrong = {wrong, " rect_x"};
         if (got.rect_y      !== want.rect_y)      wrong = {wrong, " rect_y"};
         if (got.rect_w      !== want.rect_w)      wrong = {wrong, " rect_w"};
         if (got.rect_h      !== want.rect_h)      wrong = {wrong, " rect_h"};
         if (wrong != "") begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch in%s", wrong);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    idling_on = 1'b1;
   bit                    hold_req  = 1'b0;
   int                    stall_cycles = 0;
   viewport_board         board = new();

   tvc_req_if req_if();
   tvc_rsp_if rsp_if();

   tile_viewport_clip_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always #5 clock = ~clock;

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tile_viewport_clip_core verification failed");
         $finish;
      end
   end

   task automatic send_word(req_word_type w);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.kind     <= w.kind;
      req_if.pos_x    <= w.pos_x;
      req_if.pos_y    <= w.pos_y;
      req_if.tile_col <= w.tile_col;
      req_if.tile_row <= w.tile_row;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_word(w);
   endtask

   task automatic update(int x, int y);
      req_word_type w;
      w          = '0;
      w.kind     = KIND_UPDATE;
      w.pos_x    = x[POS_W-1:0];
      w.pos_y    = y[POS_W-1:0];
      w.tile_col = TILE_IDX_W'($urandom);
      w.tile_row = TILE_IDX_W'($urandom);
      send_word(w);
   endtask

   task automatic query(bit [TILE_IDX_W-1:0] c, bit [TILE_IDX_W-1:0] r);
      req_word_type w;
      w          = '0;
      w.kind     = KIND_QUERY;
      w.pos_x    = POS_W'($urandom);
      w.pos_y    = POS_W'($urandom);
      w.tile_col = c;
      w.tile_row = r;
      send_word(w);
   endtask

   // drop valid and hold until every expected word has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic load_settings(int tw, int th, int ww, int wh, int vw, int vh);
      drain();
      csr_put(CSR_TILE_WIDTH, CSR_DATA_W'(tw));
      csr_put(CSR_TILE_HEIGHT, CSR_DATA_W'(th));
      csr_put(CSR_WORLD_WIDTH, CSR_DATA_W'(ww));
      csr_put(CSR_WORLD_HEIGHT, CSR_DATA_W'(wh));
      csr_put(CSR_WIN_WIDTH, CSR_DATA_W'(vw));
      csr_put(CSR_WIN_HEIGHT, CSR_DATA_W'(vh));
      csr_put(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic int pick_pos(longint tsz, longint span, longint win);
      longint lim;
      lim = span - win;
      case ($urandom_range(0, 7))
         0:       return int'($urandom);
         1, 2:    return int'(lim) + int'($urandom_range(0, 32'(2 * tsz))) - int'(tsz);
         3:       return int'($urandom_range(0, 32'(2 * tsz))) - int'(tsz);
         default: return int'($urandom_range(0, 32'(span)));
      endcase
   endfunction

   function automatic bit [TILE_IDX_W-1:0] pick_tile(bit [TILE_IDX_W-1:0] first,
                                                     bit [TILE_IDX_W-1:0] last);
      case ($urandom_range(0, 7))
         0, 1:    return first;
         2, 3:    return last;
         4:       return first + 1'b1;
         5:       return last - 1'b1;
         6:       return TILE_IDX_W'($urandom_range(first, last));
         default: return TILE_IDX_W'($urandom);
      endcase
   endfunction

   task automatic random_word();
      longint tw, th;
      if ($urandom_range(0, 99) < 30) begin
         tw = board.bounded(board.tile_w, MAX_TILE_SIZE);
         th = board.bounded(board.tile_h, MAX_TILE_SIZE);
         update(pick_pos(tw, tw * board.bounded(board.world_w, MAX_WORLD_TILES),
                         board.bounded(board.win_w, WIN_MAX)),
                pick_pos(th, th * board.bounded(board.world_h, MAX_WORLD_TILES),
                         board.bounded(board.win_h, WIN_MAX)));
      end else begin
         query(pick_tile(board.first_col, board.last_col),
               pick_tile(board.first_row, board.last_row));
      end
   endtask

   function automatic int pick_tile_size();
      return $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 32);
   endfunction

   function automatic int pick_world();
      return $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 64);
   endfunction

   function automatic int pick_window();
      return $urandom_range(0, 5) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 600);
   endfunction

   // result side: random ready bursts, one long hold-off on request
   task automatic rsp_cycle();
      rsp_word_type got;
      @(posedge clock);
      if (rsp_if.valid && rsp_if.ready) begin
         got = rsp_word_type'{rsp_if.first_col, rsp_if.first_row, rsp_if.last_col,
                              rsp_if.last_row, rsp_if.left_skip, rsp_if.top_skip,
                              rsp_if.right_used, rsp_if.bottom_used, rsp_if.rect_x,
                              rsp_if.rect_y, rsp_if.rect_w, rsp_if.rect_h};
         board.check_word(got);
      end
   endtask

   initial begin
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) rsp_cycle();
            hold_req = 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) rsp_cycle();
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_cycle();
         end
      end
   end

   initial begin
      int phase;
      int n;
      csr_we          <= 1'b0;
      csr_index       <= CSR_TILE_WIDTH;
      csr_wdata       <= '0;
      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_UPDATE;
      req_if.pos_x    <= '0;
      req_if.pos_y    <= '0;
      req_if.tile_col <= '0;
      req_if.tile_row <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 16x16 tiles, 64x64 world, 320x240 window
      query(12'd0, 12'd0);
      query(12'd4095, 12'd4095);
      update(-1048576, -1048576);
      update(1048575, 1048575);
      query(board.first_col, board.first_row);
      query(board.last_col, board.last_row);
      update(37, 21);
      query(board.first_col, board.first_row);
      query(board.last_col, board.last_row);
      query(board.first_col + 12'd1, board.last_row - 12'd1);
      update(704, 784);
      query(board.last_col, board.last_row);

      // big skip, then shrink the tile so the stored skip no longer fits
      load_settings(256, 256, 16, 16, 300, 300);
      update(250, 250);
      load_settings(16, 16, 64, 64, 320, 240);
      query(board.first_col, board.first_row);

      // zero sizes act as one
      load_settings(0, 0, 0, 0, 0, 0);
      update(5, -5);
      query(12'd0, 12'd0);
      query(12'd1, 12'd1);

      // oversized tile and world clamp to their maximum
      load_settings(511, 300, 8191, 8191, 8191, 8191);
      update(1048575, 3);
      query(board.last_col, board.last_row);

      // window wider than the world: position pinned at zero, last tile past the world
      load_settings(1, 1, 4096, 1, 8191, 4096);
      update(100, -1);
      query(board.last_col, board.last_row);
      query(board.first_col, board.first_row);

      for (phase = 0; phase < PHASES; phase++) begin
         load_settings(pick_tile_size(), pick_tile_size(), pick_world(), pick_world(),
                       pick_window(), pick_window());
         if (phase == PHASES - 1) idling_on = 1'b0;
         for (n = 0; n < PHASE_WORDS; n++) begin
            // stall the result side while words keep coming
            if (phase == 2 && n == 20) hold_req = 1'b1;
            random_word();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tile_viewport_clip_core verification clean");
      end else begin
         $display("tile_viewport_clip_core verification failed");
      end
      $finish;
   end

endmodule

>>> tile_viewport_clip_core.f
sv/tvc_pkg.sv
sv/tvc_req_if.sv
sv/tvc_rsp_if.sv
sv/tvc_div.sv
sv/tvc_dp.sv
sv/tvc_ctrl.sv
sv/tile_viewport_clip_core.sv
test/testbench.sv
